/* hw/rtl/pwdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes and payload types shared by the PID core and its
// stream interfaces.
// ----------------------------------------------------------------------------
package pwdc_pkg;

  localparam int GAIN_FRAC_BITS = 8;

  localparam int CFG_W   = 16;
  localparam int MEAS_W  = 16;
  localparam int DRIVE_W = 17;
  localparam int ERR_W   = MEAS_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PROD_W  = CFG_W + ERR_W;
  localparam int PRODD_W = CFG_W + DIFF_W;
  localparam int ISUM_W  = CFG_W + GAIN_FRAC_BITS + 1;
  localparam int IACC_W  = ((ISUM_W > PROD_W) ? ISUM_W : PROD_W) + 1;
  localparam int SUM_W   = PRODD_W + 2;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef logic signed [MEAS_W-1:0]  meas_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DEAD_BAND = 3'd3,
    REG_INT_LIMIT = 3'd4,
    REG_OUT_LIMIT = 3'd5,
    REG_SETPOINT  = 3'd6
  } reg_idx_e;

endpackage

/* hw/rtl/pwdc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller stream interfaces
// Valid/ready channels for the measurement input and the drive output.
// ----------------------------------------------------------------------------
interface pwdc_meas_if;
  logic           valid;
  logic           ready;
  pwdc_pkg::meas_t measured_value;

  modport source (output valid, output measured_value, input ready);
  modport sink   (input valid, input measured_value, output ready);
endinterface

interface pwdc_drive_if;
  logic             valid;
  logic             ready;
  pwdc_pkg::drive_t drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

/* hw/rtl/pid_with_deadband_and_clamps_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional PID core with deadband and anti-windup clamps
// One measurement in, one clamped drive value out; integral and output are
// held while the error stays inside the deadband.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  meas_i    in   valid/ready          measured_value  (16b signed)
//  drive_o   out  valid/ready          drive_value     (17b signed)
//  apb       in   psel/penable/pready  7 x 16b registers at 4*i
//
//  One measurement per cycle unless the drive output stalls: input register,
//  combinational PID datapath, result register; drive valid rises as it loads.
//  The integral and previous error are updated as the item leaves the input
//  register, so consecutive items chain without bubbles.
//  Reset clears the gains, limits, valid flags and controller state to zero.
//  A stalled drive output holds the pipeline; meas_i.ready drops only when
//  both stages are full.
// ----------------------------------------------------------------------------
module pid_with_deadband_and_clamps_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pwdc_meas_if.sink                     meas_i,
  pwdc_drive_if.source                  drive_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pwdc_pkg::PDATA_W-1:0]  pwdata,
  output logic [pwdc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pwdc_pkg::*;

  logic signed [CFG_W-1:0] gain_p_q, gain_i_q, gain_d_q, setpoint_q;
  logic        [CFG_W-1:0] dead_band_q, int_limit_q, out_limit_q;

  logic                     s1_valid_q;
  meas_t                    meas_q;
  logic                     out_valid_q;
  drive_t                   drive_q;

  logic signed [ERR_W-1:0]  prev_err_q;
  logic signed [ISUM_W-1:0] isum_q;
  drive_t                   held_q;

  logic                     out_take;
  logic                     s1_fire;
  logic                     in_fire;
  logic                     cfg_wr;
  reg_idx_e                 cfg_idx;

  logic signed [ERR_W-1:0]   err;
  logic        [ERR_W-1:0]   mag;
  logic                      outside;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_p;
  logic signed [PROD_W-1:0]  prod_i;
  logic signed [PRODD_W-1:0] prod_d;
  logic signed [IACC_W-1:0]  iacc;
  logic signed [IACC_W-1:0]  ilim;
  logic signed [IACC_W-1:0]  iclamp;
  logic signed [ISUM_W-1:0]  isum_d;
  logic signed [SUM_W-1:0]   p_term, i_term, d_term, sum, olim, oclamp;
  drive_t                    held_d;

  assign cfg_idx  = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign out_take = !out_valid_q || drive_o.ready;
  assign s1_fire  = s1_valid_q && out_take;
  assign meas_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = meas_i.valid && meas_i.ready;

  assign drive_o.valid       = out_valid_q;
  assign drive_o.drive_value = drive_q;

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_P:    prdata = PDATA_W'(gain_p_q);
      REG_GAIN_I:    prdata = PDATA_W'(gain_i_q);
      REG_GAIN_D:    prdata = PDATA_W'(gain_d_q);
      REG_DEAD_BAND: prdata = PDATA_W'(dead_band_q);
      REG_INT_LIMIT: prdata = PDATA_W'(int_limit_q);
      REG_OUT_LIMIT: prdata = PDATA_W'(out_limit_q);
      REG_SETPOINT:  prdata = PDATA_W'(setpoint_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      dead_band_q <= '0;
      int_limit_q <= '0;
      out_limit_q <= '0;
      setpoint_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN_P:    gain_p_q    <= pwdata[CFG_W-1:0];
        REG_GAIN_I:    gain_i_q    <= pwdata[CFG_W-1:0];
        REG_GAIN_D:    gain_d_q    <= pwdata[CFG_W-1:0];
        REG_DEAD_BAND: dead_band_q <= pwdata[CFG_W-1:0];
        REG_INT_LIMIT: int_limit_q <= pwdata[CFG_W-1:0];
        REG_OUT_LIMIT: out_limit_q <= pwdata[CFG_W-1:0];
        REG_SETPOINT:  setpoint_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_comb begin
    err     = ERR_W'(setpoint_q) - ERR_W'(meas_q);
    mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    outside = mag > ERR_W'(dead_band_q);
    diff    = DIFF_W'(err) - DIFF_W'(prev_err_q);
    prod_p  = PROD_W'(gain_p_q) * PROD_W'(err);
    prod_i  = PROD_W'(gain_i_q) * PROD_W'(err);
    prod_d  = PRODD_W'(gain_d_q) * PRODD_W'(diff);

    iacc = IACC_W'(isum_q) + IACC_W'(prod_i);
    ilim = $signed({{(IACC_W-CFG_W){1'b0}}, int_limit_q}) <<< GAIN_FRAC_BITS;
    if (iacc > ilim) begin
      iclamp = ilim;
    end else if (iacc < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = iacc;
    end
    isum_d = ISUM_W'(iclamp);

    p_term = SUM_W'(prod_p >>> GAIN_FRAC_BITS);
    i_term = SUM_W'(isum_d >>> GAIN_FRAC_BITS);
    d_term = SUM_W'(prod_d >>> GAIN_FRAC_BITS);
    sum    = p_term + i_term + d_term;
    olim   = $signed({{(SUM_W-CFG_W){1'b0}}, out_limit_q});
    if (sum > olim) begin
      oclamp = olim;
    end else if (sum < -olim) begin
      oclamp = -olim;
    end else begin
      oclamp = sum;
    end
    held_d = outside ? DRIVE_W'(oclamp) : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_err_q  <= '0;
      isum_q      <= '0;
      held_q      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        prev_err_q  <= err;
        if (outside) begin
          isum_q <= isum_d;
          held_q <= held_d;
        end
      end else if (drive_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meas_q <= meas_i.measured_value;
    end
    if (s1_fire) begin
      drive_q <= held_d;
    end
  end

`ifndef SYNTHESIS
  a_hold_in_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !outside) |=> ($stable(isum_q) && $stable(held_q)))
    else $error("integral or held output changed inside deadband");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (out_valid_q && drive_q == held_q))
    else $error("result register does not match held output");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !meas_i.ready |-> (s1_valid_q && out_valid_q && !drive_o.ready))
    else $error("input stalled while pipeline has room");
`endif

endmodule
